// ----- rtl/rwlm_pkg.sv -----
// Shared types and constants of the reader-writer lock manager.
`timescale 1ns / 1ps
package rwlm_pkg;
	localparam logic [2:0] CMD_INIT = 3'd0;
	localparam logic [2:0] CMD_DESTROY = 3'd1;
	localparam logic [2:0] CMD_READ = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_TRY_READ = 3'd4;
	localparam logic [2:0] CMD_TRY_WRITE = 3'd5;
	localparam logic [2:0] CMD_UNLOCK = 3'd6;
	localparam logic [2:0] CMD_BAD = 3'd7;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_QUEUED = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_BUSY = 3'd3;
	localparam logic [2:0] ST_DEADLOCK = 3'd4;
	localparam logic [2:0] ST_NOT_OWNER = 3'd5;
	localparam logic [2:0] ST_NO_RESOURCE = 3'd6;
	localparam logic [2:0] ST_NOT_SUPPORTED = 3'd7;

	localparam logic [1:0] MODE_FREE = 2'd0;
	localparam logic [1:0] MODE_READ = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	localparam logic [1:0] LS_NONE = 2'd0;
	localparam logic [1:0] LS_INIT = 2'd1;
	localparam logic [1:0] LS_DEAD = 2'd2;

	localparam int QUEUE_DEPTH = 16;
	localparam logic [8:0] USER_TOTAL_MAX = 9'd511;
	localparam logic [7:0] READER_TOTAL_MAX = 8'd255;

	// One result item as it leaves the block.
	typedef struct packed {
		logic       last;
		logic       wake_is_write;
		logic [3:0] wake_id;
		logic       wake_valid;
		logic [2:0] status;
	} result_t;
endpackage

// ----- rtl/reader_writer_lock_manager.sv -----
// Top level of the reader-writer lock manager.
//
// One lock shared by NUM_REQUESTERS requesters. Commands enter on s_axis
// (tdata: command[2:0], requester_id[6:3], process_shared[7]); each command
// gives one or more results on m_axis (tdata: status[2:0], wake_valid[3],
// wake_id[7:4], wake_is_write[8]; tlast marks the final result of a command).
// After a command is accepted its hold count is read from memory (S_READ),
// the command is decided and written back (S_EXEC), and the result is
// offered in S_OUT. An unlock that wakes waiters walks the wait queue memory:
// each grant waits in S_WALK for its entry to be read, and a reader grant
// also passes S_PEEK to read the entry behind it before its grant is offered.
// Commands are handled one at a time: a result waits in the output register
// while the receiver stalls, and no command is accepted until the final result
// of the previous one is taken.
// Reset clears the lock state and runs a clearing pass over the hold count
// memory, during which no command is accepted; an init of a lock that is not
// yet initialised runs the same pass after its result is taken.
`timescale 1ns / 1ps
module reader_writer_lock_manager import rwlm_pkg::*; #(
	parameter int NUM_REQUESTERS = 16,
	parameter int HOLD_COUNT_MAX = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // command[2:0], requester_id[6:3], process_shared[7]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // status[2:0], wake_valid[3], wake_id[7:4], wake_is_write[8]
	output logic        m_axis_tlast
);
	localparam int IDW = 4;
	localparam int HMW = $clog2(HOLD_COUNT_MAX + 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_READ  = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_WALK  = 7'b0010000,
		S_PEEK  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [1:0] lock_status_q, hold_mode_q;
	logic writer_waiting_q, writer_valid_q;
	logic [IDW-1:0] writer_owner_q;
	logic [7:0] reader_total_q;
	logic [8:0] user_total_q;
	logic [3:0] queue_head_q;
	logic [4:0] queue_fill_q;
	logic [IDW-1:0] clr_idx_q;
	logic [2:0] cmd_q;
	logic [IDW-1:0] id_q;
	logic pshared_q;
	logic walk_first_q;
	result_t res_q;
	logic out_more_q;

	// Memories: hold counts and the wait queue, synchronous read.
	logic [HMW-1:0] hold_mem [2**IDW];
	logic [4:0] queue_mem [QUEUE_DEPTH];
	logic [HMW-1:0] hold_rd_q;
	logic [4:0] queue_rd_q;
	logic hold_we, queue_we;
	logic [IDW-1:0] hold_wa;
	logic [HMW-1:0] hold_wd;
	logic [3:0] queue_wa, queue_ra;
	logic [4:0] queue_wd;

	always_ff @(posedge clk) begin
		if (hold_we)
			hold_mem[hold_wa] <= hold_wd;
		hold_rd_q <= hold_mem[id_q];
		if (queue_we)
			queue_mem[queue_wa] <= queue_wd;
		queue_rd_q <= queue_mem[queue_ra];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {7'd0, res_q.wake_is_write, res_q.wake_id, res_q.wake_valid,
		res_q.status};
	assign m_axis_tlast = res_q.last;

	// Decision on a lock command.
	logic id_ok, want_w, is_try, grant, hold_full;
	logic [2:0] lk_st;
	always_comb begin
		id_ok = (32'(id_q) < NUM_REQUESTERS);
		want_w = (cmd_q == CMD_WRITE) || (cmd_q == CMD_TRY_WRITE);
		is_try = (cmd_q == CMD_TRY_READ) || (cmd_q == CMD_TRY_WRITE);
		hold_full = (32'(hold_rd_q) >= 32'(HOLD_COUNT_MAX)) || (user_total_q >= USER_TOTAL_MAX);
		if (want_w)
			grant = (hold_mode_q == MODE_FREE) && !writer_waiting_q;
		else
			grant = ((hold_mode_q == MODE_FREE) || (hold_mode_q == MODE_READ)) &&
				!writer_waiting_q;
		priority if (grant) begin
			lk_st = (hold_full || (!want_w && reader_total_q >= READER_TOTAL_MAX)) ?
				ST_NO_RESOURCE : ST_OK;
		end else if (writer_valid_q && writer_owner_q == id_q) begin
			lk_st = ST_DEADLOCK;
		end else if (is_try) begin
			lk_st = ST_BUSY;
		end else if (hold_full || queue_fill_q >= 5'(QUEUE_DEPTH)) begin
			lk_st = ST_NO_RESOURCE;
		end else begin
			lk_st = ST_QUEUED;
		end
	end

	// After an unlock the user and reader totals drop by one.
	logic [8:0] ut_dec;
	logic [7:0] rt_dec;
	assign ut_dec = (user_total_q != 9'd0) ? user_total_q - 9'd1 : user_total_q;
	assign rt_dec = (reader_total_q != 8'd0) ? reader_total_q - 8'd1 : reader_total_q;

	// Status of the first result and whether an unlock starts a queue walk.
	logic [2:0] exec_st;
	logic unlock_ok, wake_start;
	always_comb begin
		unlock_ok = (cmd_q == CMD_UNLOCK) && (lock_status_q == LS_INIT) && id_ok &&
			(hold_rd_q != '0);
		wake_start = unlock_ok && (queue_fill_q != 5'd0) && (rt_dec == 8'd0);
		priority if (cmd_q == CMD_INIT) begin
			if (lock_status_q == LS_INIT)
				exec_st = ST_BUSY;
			else
				exec_st = pshared_q ? ST_NOT_SUPPORTED : ST_OK;
		end else if (cmd_q == CMD_DESTROY) begin
			exec_st = (user_total_q != 9'd0) ? ST_BUSY : ST_OK;
		end else if (cmd_q == CMD_BAD || lock_status_q != LS_INIT || !id_ok) begin
			exec_st = ST_INVALID;
		end else if (cmd_q == CMD_UNLOCK) begin
			exec_st = (hold_rd_q == '0) ? ST_NOT_OWNER : ST_OK;
		end else begin
			exec_st = lk_st;
		end
	end

	always_comb begin
		hold_we = 1'b0;
		hold_wa = id_q;
		hold_wd = hold_rd_q;
		queue_we = 1'b0;
		queue_wa = 4'(queue_head_q + queue_fill_q[3:0]);
		queue_wd = {want_w, id_q};
		queue_ra = queue_head_q;
		if (state_q == S_CLEAR) begin
			hold_we = 1'b1;
			hold_wa = clr_idx_q;
			hold_wd = '0;
		end else if (state_q == S_EXEC && lock_status_q == LS_INIT && id_ok) begin
			if (cmd_q == CMD_UNLOCK) begin
				hold_we = (hold_rd_q != '0);
				hold_wd = hold_rd_q - HMW'(1);
			end else if (cmd_q >= CMD_READ && cmd_q <= CMD_TRY_WRITE) begin
				hold_we = (lk_st == ST_OK) || (lk_st == ST_QUEUED);
				hold_wd = hold_rd_q + HMW'(1);
				queue_we = (lk_st == ST_QUEUED);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lock_status_q <= LS_NONE;
			hold_mode_q <= MODE_FREE;
			writer_waiting_q <= 1'b0;
			writer_valid_q <= 1'b0;
			writer_owner_q <= '0;
			reader_total_q <= '0;
			user_total_q <= '0;
			queue_head_q <= '0;
			queue_fill_q <= '0;
			clr_idx_q <= '0;
			walk_first_q <= 1'b0;
			out_more_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 4'd1;
					if (clr_idx_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					res_q <= '{last: 1'b1, wake_is_write: 1'b0, wake_id: '0,
						wake_valid: 1'b0, status: exec_st};
					// An init of a lock not yet initialised clears the hold counts after its result is taken.
					out_more_q <= (cmd_q == CMD_INIT) && (lock_status_q != LS_INIT);
					walk_first_q <= 1'b1;
					state_q <= wake_start ? S_WALK : S_OUT;
					priority if (cmd_q == CMD_INIT) begin
						if (lock_status_q != LS_INIT) begin
							lock_status_q <= LS_INIT;
							hold_mode_q <= MODE_FREE;
							writer_waiting_q <= 1'b0;
							writer_valid_q <= 1'b0;
							writer_owner_q <= '0;
							reader_total_q <= '0;
							user_total_q <= '0;
							queue_head_q <= '0;
							queue_fill_q <= '0;
						end
					end else if (cmd_q == CMD_DESTROY) begin
						if (user_total_q == 9'd0)
							lock_status_q <= LS_DEAD;
					end else if (cmd_q == CMD_BAD || lock_status_q != LS_INIT || !id_ok) begin
						// Rejected command: nothing changes.
					end else if (cmd_q == CMD_UNLOCK) begin
						if (unlock_ok) begin
							user_total_q <= ut_dec;
							reader_total_q <= rt_dec;
							if (!wake_start && ut_dec == 9'd0) begin
								writer_waiting_q <= 1'b0;
								hold_mode_q <= MODE_FREE;
								writer_valid_q <= 1'b0;
								writer_owner_q <= '0;
							end
						end
					end else begin
						if (lk_st == ST_OK) begin
							user_total_q <= user_total_q + 9'd1;
							if (want_w) begin
								hold_mode_q <= MODE_WRITE;
								writer_valid_q <= 1'b1;
								writer_owner_q <= id_q;
							end else begin
								hold_mode_q <= MODE_READ;
								reader_total_q <= reader_total_q + 8'd1;
							end
						end else if (lk_st == ST_QUEUED) begin
							user_total_q <= user_total_q + 9'd1;
							queue_fill_q <= queue_fill_q + 5'd1;
							if (want_w)
								writer_waiting_q <= 1'b1;
						end
					end
				end
				S_WALK: begin
					// The first cycle waits for the head entry to be read.
					walk_first_q <= !walk_first_q;
					if (!walk_first_q) begin
						queue_head_q <= queue_head_q + 4'd1;
						queue_fill_q <= queue_fill_q - 5'd1;
						out_more_q <= 1'b0;
						res_q <= '{last: queue_rd_q[4], wake_is_write: queue_rd_q[4],
							wake_id: queue_rd_q[3:0], wake_valid: 1'b1, status: ST_OK};
						if (queue_rd_q[4]) begin
							// A writer at the head is granted alone.
							state_q <= S_OUT;
							if (user_total_q == 9'd0) begin
								writer_waiting_q <= 1'b0;
								hold_mode_q <= MODE_FREE;
								writer_valid_q <= 1'b0;
								writer_owner_q <= '0;
							end else begin
								hold_mode_q <= MODE_WRITE;
								writer_valid_q <= 1'b1;
								writer_owner_q <= queue_rd_q[3:0];
								if (queue_fill_q == 5'd1)
									writer_waiting_q <= 1'b0;
							end
						end else begin
							// A reader: look at the entry behind it before offering the grant.
							state_q <= S_PEEK;
							hold_mode_q <= MODE_READ;
							writer_valid_q <= 1'b0;
							writer_owner_q <= '0;
							if (reader_total_q < READER_TOTAL_MAX)
								reader_total_q <= reader_total_q + 8'd1;
						end
					end
				end
				S_PEEK: begin
					walk_first_q <= 1'b0;
					if (!walk_first_q) begin
						state_q <= S_OUT;
						if (queue_fill_q == 5'd0 || queue_rd_q[4]) begin
							// The run of readers ends with this grant.
							res_q.last <= 1'b1;
							out_more_q <= 1'b0;
							if (queue_fill_q == 5'd0 || user_total_q == 9'd0)
								writer_waiting_q <= 1'b0;
							if (user_total_q == 9'd0) begin
								hold_mode_q <= MODE_FREE;
								writer_valid_q <= 1'b0;
								writer_owner_q <= '0;
							end
						end else begin
							out_more_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						walk_first_q <= 1'b1;
						priority if (!out_more_q)
							state_q <= S_IDLE;
						else if (cmd_q == CMD_INIT)
							state_q <= S_CLEAR;
						else
							state_q <= S_WALK;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			cmd_q <= s_axis_tdata[2:0];
			id_q <= s_axis_tdata[6:3];
			pshared_q <= s_axis_tdata[7];
		end
	end
endmodule
